// ===== hdl/tqws_pkg.sv =====
package tqws_pkg;

    localparam int QUEUE_DEPTH = 1024;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int ID_W     = 16;
    localparam int QUOTA_W  = 8;
    localparam int RUN_W    = 8;
    localparam int STATUS_W = 2;
    localparam int PDATA_W  = 32;
    localparam int PADDR_W  = 3;

    localparam logic [RUN_W-1:0]   RUN_MAX     = '1;
    localparam logic [QUOTA_W-1:0] QUOTA_A_RST = 8'd2;
    localparam logic [QUOTA_W-1:0] QUOTA_B_RST = 8'd1;

    localparam logic [PADDR_W-1:0] ADDR_QUOTA_A = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_QUOTA_B = 3'd4;

    typedef enum logic [STATUS_W-1:0] {
        ST_PUSHED = 2'd0,
        ST_SERVED = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctrl;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

// ===== hdl/tqws_if.sv =====
interface tqws_in_if;
    import tqws_pkg::*;

    logic            valid;
    logic            ready;
    logic            op;
    logic [ID_W-1:0] customer_id;

    modport source (output valid, output op, output customer_id, input ready);
    modport sink   (input valid, input op, input customer_id, output ready);
endinterface

interface tqws_out_if;
    import tqws_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     served_id;
    logic                from_b;

    modport source (output valid, output status, output served_id, output from_b,
                     input ready);
    modport sink   (input valid, input status, input served_id, input from_b,
                     output ready);
endinterface

// ===== hdl/tqws_queue.sv =====
module tqws_queue import tqws_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_q_ctrl         i_ctrl,
    input  logic [ID_W-1:0] i_wr_data,
    output t_q_stat         o_stat,
    output logic [ID_W-1:0] o_rd_data
);

    logic [ID_W-1:0]   r_mem [QUEUE_DEPTH];
    logic [ID_W-1:0]   r_rd_data;
    logic [PTR_W-1:0]  r_head;
    logic [PTR_W-1:0]  r_tail;
    logic [FILL_W-1:0] r_fill;
    logic [PTR_W-1:0]  n_head;
    logic [PTR_W-1:0]  n_tail;
    logic [FILL_W-1:0] n_fill;

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_fill = r_fill;
        if (i_ctrl.push) begin
            n_tail = (r_tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;
            n_fill = r_fill + 1'b1;
        end
        if (i_ctrl.pop) begin
            n_head = (r_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_mem[r_tail] <= i_wr_data;
        end
        if (i_ctrl.pop) begin
            r_rd_data <= r_mem[r_head];
        end
    end

    assign o_stat.empty = (r_fill == '0);
    assign o_stat.full  = (r_fill == FILL_W'(QUEUE_DEPTH));
    assign o_rd_data    = r_rd_data;

endmodule

// ===== hdl/two_queue_weighted_server.sv =====
// Channel   Direction  Transfer when         Payload
// i_in      in         valid && ready        op, customer_id
// o_out     out        valid && ready        status, served_id, from_b
// APB       in         psel/penable/pwrite   quota_a @0x0, quota_b @0x4
//
// One item per cycle while the output is not stalled: the decision, queue
// pointer update and store read all happen at the transfer edge; the registered
// store read is one stage, the result register a second, and a result is offered once it reaches the result register.
// Synchronous active-low reset clears pointers, fills, run counters and loads the reset quotas.
// A stalled output holds both stages; input ready falls only when both are full.
module two_queue_weighted_server import tqws_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tqws_in_if.sink            i_in,
    tqws_out_if.source         o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [QUOTA_W-1:0] r_quota_a;
    logic [QUOTA_W-1:0] r_quota_b;
    logic [RUN_W-1:0]   r_run_a;
    logic [RUN_W-1:0]   r_run_b;
    logic [RUN_W-1:0]   n_run_a;
    logic [RUN_W-1:0]   n_run_b;
    logic [RUN_W-1:0]   run_b_inc;

    logic               r_s1_valid;
    t_status            r_s1_status;
    logic               r_s1_pop;
    logic               r_s1_from_b;
    t_status            n_status;
    logic               n_from_b;

    logic               r_out_valid;
    t_status            r_out_status;
    logic [ID_W-1:0]    r_out_id;
    logic               r_out_from_b;

    logic               accept;
    logic               s1_adv;
    logic               pop_a;
    logic               pop_b;
    t_q_ctrl            ctrl_a;
    t_q_ctrl            ctrl_b;
    t_q_stat            stat_a;
    t_q_stat            stat_b;
    logic [ID_W-1:0]    rd_a;
    logic [ID_W-1:0]    rd_b;
    logic               to_a;
    logic               push_ok;

    tqws_queue u_queue_a (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (ctrl_a),
        .i_wr_data (i_in.customer_id),
        .o_stat    (stat_a),
        .o_rd_data (rd_a)
    );

    tqws_queue u_queue_b (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (ctrl_b),
        .i_wr_data (i_in.customer_id),
        .o_stat    (stat_b),
        .o_rd_data (rd_b)
    );

    assign s1_adv     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign accept     = i_in.valid && i_in.ready;

    assign to_a      = i_in.customer_id[0];
    assign push_ok   = to_a ? !stat_a.full : !stat_b.full;
    assign run_b_inc = (r_run_b == RUN_MAX) ? r_run_b : r_run_b + 1'b1;

    always_comb begin
        pop_a    = 1'b0;
        pop_b    = 1'b0;
        n_from_b = 1'b0;
        n_run_a  = r_run_a;
        n_run_b  = r_run_b;
        if (!i_in.op) begin
            n_status = push_ok ? ST_PUSHED : ST_FULL;
        end else if ((r_run_a < r_quota_a) && !stat_a.empty) begin
            pop_a    = 1'b1;
            n_run_a  = r_run_a + 1'b1;
            n_run_b  = '0;
            n_status = ST_SERVED;
        end else if (!stat_b.empty) begin
            pop_b    = 1'b1;
            n_from_b = 1'b1;
            n_run_b  = run_b_inc;
            if (run_b_inc >= r_quota_b) begin
                n_run_a = '0;
            end
            n_status = ST_SERVED;
        end else begin
            pop_a    = !stat_a.empty;
            n_status = stat_a.empty ? ST_EMPTY : ST_SERVED;
            n_run_a  = '0;
            n_run_b  = '0;
        end
    end

    assign ctrl_a.push = accept && !i_in.op && to_a && !stat_a.full;
    assign ctrl_b.push = accept && !i_in.op && !to_a && !stat_b.full;
    assign ctrl_a.pop  = accept && pop_a;
    assign ctrl_b.pop  = accept && pop_b;

    // track the decision-stage and result-register valid flags and update the run counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_run_a     <= '0;
            r_run_b     <= '0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
                r_run_a    <= n_run_a;
                r_run_b    <= n_run_b;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_status <= n_status;
            r_s1_pop    <= pop_a || pop_b;
            r_s1_from_b <= n_from_b;
        end
        if (s1_adv) begin
            r_out_status <= r_s1_status;
            r_out_from_b <= r_s1_from_b;
            if (!r_s1_pop) begin
                r_out_id <= '0;
            end else if (r_s1_from_b) begin
                r_out_id <= rd_b;
            end else begin
                r_out_id <= rd_a;
            end
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.status    = r_out_status;
    assign o_out.served_id = r_out_id;
    assign o_out.from_b    = r_out_from_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quota_a <= QUOTA_A_RST;
            r_quota_b <= QUOTA_B_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr)
                ADDR_QUOTA_A: r_quota_a <= pwdata[QUOTA_W-1:0];
                ADDR_QUOTA_B: r_quota_b <= pwdata[QUOTA_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            ADDR_QUOTA_A: prdata = PDATA_W'(r_quota_a);
            ADDR_QUOTA_B: prdata = PDATA_W'(r_quota_b);
            default:      prdata = '0;
        endcase
    end

    assign pready = 1'b1;

endmodule

// ===== sim/tb.sv =====
module tb;
    import tqws_pkg::*;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_SERVE = 1'b1;
    localparam int   CYCLE_LIMIT = 400000;
    localparam int   SETTLE      = 6;

    typedef struct {
        t_status         status;
        logic [ID_W-1:0] served_id;
        logic            from_b;
    } t_reply;

    class server_shadow;
        logic [ID_W-1:0]    line_a[$];
        logic [ID_W-1:0]    line_b[$];
        logic [RUN_W-1:0]   run_a;
        logic [RUN_W-1:0]   run_b;
        logic [QUOTA_W-1:0] quota_a;
        logic [QUOTA_W-1:0] quota_b;
        t_reply             replies_due[$];
        int                 faults;

        function new();
            run_a   = '0;
            run_b   = '0;
            quota_a = QUOTA_A_RST;
            quota_b = QUOTA_B_RST;
            faults  = 0;
        endfunction

        function void take_request(logic op, logic [ID_W-1:0] id);
            t_reply r;
            r.status    = ST_PUSHED;
            r.served_id = '0;
            r.from_b    = 1'b0;
            if (op == OP_PUSH) begin
                if (id[0]) begin
                    if (line_a.size() < QUEUE_DEPTH) line_a.push_back(id);
                    else r.status = ST_FULL;
                end else begin
                    if (line_b.size() < QUEUE_DEPTH) line_b.push_back(id);
                    else r.status = ST_FULL;
                end
            end else if (run_a < quota_a && line_a.size() != 0) begin
                r.status    = ST_SERVED;
                r.served_id = line_a.pop_front();
                run_a       = run_a + 1'b1;
                run_b       = '0;
            end else if (line_b.size() != 0) begin
                r.status    = ST_SERVED;
                r.served_id = line_b.pop_front();
                r.from_b    = 1'b1;
                if (run_b != RUN_MAX) run_b = run_b + 1'b1;
                if (run_b >= quota_b) run_a = '0;
            end else begin
                if (line_a.size() != 0) begin
                    r.status    = ST_SERVED;
                    r.served_id = line_a.pop_front();
                end else begin
                    r.status = ST_EMPTY;
                end
                run_a = '0;
                run_b = '0;
            end
            replies_due.push_back(r);
        endfunction

        function void match_reply(logic [STATUS_W-1:0] status, logic [ID_W-1:0] served_id,
                                   logic from_b);
            t_reply r;
            if (replies_due.size() == 0) begin
                $error("unexpected transfer: status %0d served_id %0h from_b %0b",
                       status, served_id, from_b);
                faults++;
                return;
            end
            r = replies_due.pop_front();
            if (status !== r.status) begin
                $error("status: expected %0d, actual %0d", r.status, status);
                faults++;
            end
            if (served_id !== r.served_id) begin
                $error("served_id: expected %0h, actual %0h", r.served_id, served_id);
                faults++;
            end
            if (from_b !== r.from_b) begin
                $error("from_b: expected %0b, actual %0b", r.from_b, from_b);
                faults++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    tqws_in_if  in_ch();
    tqws_out_if out_ch();

    server_shadow sb = new();
    int           src_idle_pct;
    int           sink_stall_pct;
    int           cycles;

    two_queue_weighted_server u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("two_queue_weighted_server verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready)
                sb.take_request(in_ch.op, in_ch.customer_id);
            if (out_ch.valid && out_ch.ready)
                sb.match_reply(out_ch.status, out_ch.served_id, out_ch.from_b);
        end
    end

    always @(negedge i_clk) begin
        out_ch.ready = ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic set_idling(int mode);
        case (mode)
            0: begin
                src_idle_pct   = 0;
                sink_stall_pct = 0;
            end
            1: begin
                src_idle_pct   = 49;
                sink_stall_pct = 0;
            end
            2: begin
                src_idle_pct   = 0;
                sink_stall_pct = 49;
            end
            default: begin
                src_idle_pct   = 29;
                sink_stall_pct = 29;
            end
        endcase
    endtask

    task automatic offer_request(logic op, logic [ID_W-1:0] id);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid       = 1'b1;
        in_ch.op          = op;
        in_ch.customer_id = id;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (sb.replies_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic program_quota(logic [PADDR_W-1:0] addr, logic [QUOTA_W-1:0] value);
        logic [31:0] junk;
        junk = $urandom();
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = {junk[PDATA_W-1:QUOTA_W], value};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == ADDR_QUOTA_A) sb.quota_a = value;
        else sb.quota_b = value;
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[QUOTA_W-1:0] !== value) begin
            $error("prdata at %0h: expected %0d, actual %0d", addr, value,
                   prdata[QUOTA_W-1:0]);
            sb.faults++;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic random_burst(int count, int push_pct, int pause_at);
        logic            op;
        logic [ID_W-1:0] id;
        for (int k = 0; k < count; k++) begin
            if (k == pause_at) wait_drained();
            op = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_SERVE;
            id = ID_W'($urandom_range(0, 65535));
            offer_request(op, id);
        end
    endtask

    task automatic flood_queue(logic parity, int count);
        logic [ID_W-1:0] id;
        for (int k = 0; k < count; k++) begin
            id    = ID_W'($urandom_range(0, 65535));
            id[0] = parity;
            offer_request(OP_PUSH, id);
        end
    endtask

    task automatic serve_run(int count);
        for (int k = 0; k < count; k++)
            offer_request(OP_SERVE, ID_W'($urandom_range(0, 65535)));
    endtask

    initial begin
        logic [QUOTA_W-1:0] qa;
        logic [QUOTA_W-1:0] qb;
        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.op          = OP_PUSH;
        in_ch.customer_id = '0;
        out_ch.ready      = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        cycles            = 0;
        set_idling(0);
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        offer_request(OP_SERVE, 16'hFFFF);
        offer_request(OP_PUSH, 16'hFFFF);
        offer_request(OP_PUSH, 16'h0000);
        offer_request(OP_PUSH, 16'h0001);
        offer_request(OP_PUSH, 16'hFFFE);
        offer_request(OP_PUSH, 16'h0003);
        offer_request(OP_PUSH, 16'h0005);
        offer_request(OP_PUSH, 16'h0002);
        offer_request(OP_PUSH, 16'h0004);
        offer_request(OP_SERVE, 16'hAAAA);
        offer_request(OP_SERVE, 16'h5555);
        offer_request(OP_SERVE, 16'h0000);
        offer_request(OP_SERVE, 16'hFFFF);
        offer_request(OP_SERVE, 16'h0001);
        offer_request(OP_SERVE, 16'hFFFE);
        offer_request(OP_SERVE, 16'h1234);
        offer_request(OP_SERVE, 16'h8001);
        offer_request(OP_SERVE, 16'h7FFE);
        wait_drained();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin qa = 8'd2;   qb = 8'd1;   end
                1: begin qa = 8'd0;   qb = 8'd1;   end
                2: begin qa = 8'd255; qb = 8'd255; end
                3: begin qa = 8'd1;   qb = 8'd0;   end
                4: begin qa = 8'd3;   qb = 8'd2;   end
                default: begin
                    qa = QUOTA_W'($urandom_range(0, 255));
                    qb = QUOTA_W'($urandom_range(0, 255));
                end
            endcase
            program_quota(ADDR_QUOTA_A, qa);
            program_quota(ADDR_QUOTA_B, qb);
            for (int mode = 0; mode < 4; mode++) begin
                set_idling(mode);
                random_burst(20, 35 + 15 * $urandom_range(0, 2), (mode == 3) ? 10 : -1);
            end
            wait_drained();
        end

        // fill queue A past capacity, then serve with quota A at zero and quota B at its maximum
        program_quota(ADDR_QUOTA_A, 8'd0);
        program_quota(ADDR_QUOTA_B, 8'd255);
        set_idling(1);
        flood_queue(1'b1, QUEUE_DEPTH);
        offer_request(OP_PUSH, 16'hFFFF);
        offer_request(OP_PUSH, 16'h0001);
        set_idling(2);
        offer_request(OP_PUSH, 16'h0000);
        set_idling(3);
        serve_run(120);
        wait_drained();
        program_quota(ADDR_QUOTA_A, 8'd3);
        program_quota(ADDR_QUOTA_B, 8'd255);
        set_idling(0);
        serve_run(100);
        wait_drained();

        if (sb.faults == 0 && sb.replies_due.size() == 0) begin
            $display("two_queue_weighted_server verification clean");
        end else begin
            $display("two_queue_weighted_server verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/tqws_pkg.sv
hdl/tqws_if.sv
hdl/tqws_queue.sv
hdl/two_queue_weighted_server.sv
sim/tb.sv
